[sv/fla_pkg.sv]
// shared constants, codes and types of the free-list heap allocator
package fla_pkg;

  localparam int HEAP_UNITS_DEF = 4096;
  localparam int UNIT_BYTES_DEF = 8;

  localparam int BYTES_W     = 16;
  localparam int FA_W        = 12;
  localparam int ADDR_W      = 12;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 13;
  localparam int SIZE_W      = 17;
  localparam int UNITS_W     = 17;
  localparam int CMP_W       = 18;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_W-1:0] MIN_GROW_RST = 13'd1024;

  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 2'd0,
    ST_OOS   = 2'd1,
    ST_FREED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_UNITS, S_A_FIRST, S_A_NEXT, S_A_CHK, S_A_MOD, S_A_RET2,
    S_F_CHK, S_R_BEGIN, S_R_CHK, S_R_RDBP, S_R_UPPER, S_R_LOWER, S_R_END, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SETUP, OP_UNITS,
    OP_A_FIRST, OP_A_NEXT, OP_A_STEP, OP_A_EXACT, OP_A_SPLIT, OP_A_MOD,
    OP_A_TAIL, OP_A_GROW, OP_A_FAIL, OP_A_RET, OP_A_RET2,
    OP_R_BEGIN, OP_R_STEP, OP_R_FOUND, OP_R_RDBP, OP_R_UPPER, OP_R_LOWER,
    OP_FREED, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic is_free;
    logic fit;
    logic exact;
    logic at_rover;
    logic grow_fail;
    logic a_over;
    logic r_over;
    logic mod_big;
    logic free_skip;
    logic found;
  } dp_stat_t;

endpackage

[sv/fla_ctrl.sv]
// sequencer for allocate and free requests over the header memory
module fla_ctrl
  import fla_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  state_t state_r, state_nxt;
  logic   grow_r, grow_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grow_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grow_r      <= grow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    grow_nxt      = grow_r;
    out_valid_nxt = out_valid_r && !out_tready;
    op            = OP_NONE;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op        = OP_LOAD;
          grow_nxt  = 1'b0;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        op        = OP_SETUP;
        state_nxt = stat.is_free ? S_F_CHK : S_UNITS;
      end
      S_UNITS: begin
        op        = OP_UNITS;
        state_nxt = S_A_FIRST;
      end
      S_A_FIRST: begin
        op        = OP_A_FIRST;
        state_nxt = S_A_NEXT;
      end
      S_A_NEXT: begin
        op        = OP_A_NEXT;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (stat.fit) begin
          op        = stat.exact ? OP_A_EXACT : OP_A_SPLIT;
          state_nxt = stat.exact ? S_DONE : S_A_MOD;
        end else if (stat.at_rover) begin
          // wrapped round the whole list: grow the arena or give up
          if (stat.grow_fail) begin
            op        = OP_A_FAIL;
            state_nxt = S_DONE;
          end else begin
            op        = OP_A_GROW;
            grow_nxt  = 1'b1;
            state_nxt = S_R_BEGIN;
          end
        end else if (stat.a_over) begin
          op        = OP_A_FAIL;
          state_nxt = S_DONE;
        end else begin
          op = OP_A_STEP;
        end
      end
      S_A_MOD: begin
        if (stat.mod_big) begin
          op = OP_A_MOD;
        end else begin
          op        = OP_A_TAIL;
          state_nxt = S_DONE;
        end
      end
      S_A_RET2: begin
        if (stat.a_over) begin
          op        = OP_A_FAIL;
          state_nxt = S_DONE;
        end else begin
          op        = OP_A_RET2;
          state_nxt = S_A_CHK;
        end
      end
      S_F_CHK: begin
        if (stat.free_skip) begin
          op        = OP_FREED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_R_BEGIN;
        end
      end
      S_R_BEGIN: begin
        op        = OP_R_BEGIN;
        state_nxt = S_R_CHK;
      end
      S_R_CHK: begin
        if (stat.found) begin
          op        = OP_R_FOUND;
          state_nxt = S_R_RDBP;
        end else if (stat.r_over) begin
          state_nxt = S_R_END;
        end else begin
          op = OP_R_STEP;
        end
      end
      S_R_RDBP: begin
        op        = OP_R_RDBP;
        state_nxt = S_R_UPPER;
      end
      S_R_UPPER: begin
        op        = OP_R_UPPER;
        state_nxt = S_R_LOWER;
      end
      S_R_LOWER: begin
        op        = OP_R_LOWER;
        state_nxt = S_R_END;
      end
      S_R_END: begin
        // a release started by arena growth resumes the search at the rover
        if (grow_r) begin
          op        = OP_A_RET;
          grow_nxt  = 1'b0;
          state_nxt = S_A_RET2;
        end else begin
          op        = OP_FREED;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          op            = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

[sv/fla_dp.sv]
// header memory, list pointers, arithmetic and result registers
module fla_dp
  import fla_pkg::*;
#(
  parameter int HEAP_UNITS = HEAP_UNITS_DEF,
  parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_op,
  input  logic [BYTES_W-1:0]  in_bytes,
  input  logic [FA_W-1:0]     in_fa,
  input  dp_op_t              op,
  output dp_stat_t            stat,
  output logic [ADDR_W-1:0]   res_addr,
  output status_t             res_status
);

  localparam int AW         = $clog2(HEAP_UNITS);
  localparam int BW         = $clog2(HEAP_UNITS + 1);
  localparam int X_W        = BYTES_W + 1;
  localparam int UB_L       = $clog2(UNIT_BYTES);
  localparam int K          = X_W + UB_L;
  localparam int M_W        = K + 1;
  localparam int RECIP      = ((1 << K) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int PROD_W     = X_W + M_W;
  localparam int STEP_LIMIT = 4 * HEAP_UNITS + 16;
  localparam int STEP_W     = $clog2(STEP_LIMIT + 1);

  localparam logic [M_W-1:0]   RECIP_V = M_W'(RECIP);
  localparam logic [CMP_W-1:0] HEAP_V  = CMP_W'(HEAP_UNITS);
  localparam logic [CMP_W-1:0] ONE_V   = CMP_W'(1);

  // header memory: block size and next-free index per unit
  logic [SIZE_W-1:0] size_mem [HEAP_UNITS];
  logic [AW-1:0]     next_mem [HEAP_UNITS];

  logic [SIZE_W-1:0] rd_size_r;
  logic [AW-1:0]     rd_next_r;
  logic [AW-1:0]     rd_addr, sz_wa, nx_wa;
  logic              sz_we, nx_we;
  logic [SIZE_W-1:0] sz_wd;
  logic [AW-1:0]     nx_wd;

  // control state
  logic [AW-1:0]     rover_r;
  logic [BW-1:0]     brk_r;
  logic              started_r;
  logic [CFG_W-1:0]  min_grow_r;

  // working registers
  logic              op_r;
  logic [X_W-1:0]    x_r;
  logic [FA_W-1:0]   fa_r;
  logic [PROD_W-1:0] prod_r;
  logic [UNITS_W-1:0] units_r;
  logic [AW-1:0]     p_r, prev_r, bp_r, n_r, next_bp_r;
  logic [SIZE_W-1:0] size_p_r, size_bp_r;
  logic [CMP_W-1:0]  q_r;
  logic [STEP_W-1:0] a_steps_r, r_steps_r;
  logic [ADDR_W-1:0] pend_addr_r, out_addr_r;
  status_t           pend_st_r, out_st_r;

  logic [UNITS_W-1:0] grow_units;
  logic [CMP_W-1:0]   room, split_q, up_full, low_full, up_chk, low_chk;
  logic [CMP_W-1:0]   fa_ext, bp_from_fa, p_plus1, q_plus1, brk_sum;
  logic [SIZE_W-1:0]  rem, up_sum, low_sum;
  logic               upper, lower;

  assign grow_units = (UNITS_W'(min_grow_r) > units_r) ? UNITS_W'(min_grow_r) : units_r;
  assign room       = HEAP_V - CMP_W'(brk_r);
  assign brk_sum    = CMP_W'(brk_r) + CMP_W'(grow_units);
  assign rem        = rd_size_r - SIZE_W'(units_r);
  assign split_q    = CMP_W'(p_r) + CMP_W'(rem);
  assign up_chk     = CMP_W'(bp_r) + CMP_W'(size_bp_r);
  assign low_chk    = CMP_W'(p_r) + CMP_W'(size_p_r);
  assign upper      = (up_chk == CMP_W'(n_r));
  assign lower      = (low_chk == CMP_W'(bp_r));
  assign up_full    = CMP_W'(size_bp_r) + CMP_W'(rd_size_r);
  assign low_full   = CMP_W'(size_p_r) + CMP_W'(size_bp_r);
  assign up_sum     = up_full[SIZE_W-1:0];
  assign low_sum    = low_full[SIZE_W-1:0];
  assign fa_ext     = CMP_W'(fa_r);
  assign bp_from_fa = fa_ext - ONE_V;
  assign p_plus1    = CMP_W'(p_r) + ONE_V;
  assign q_plus1    = q_r + ONE_V;

  always_comb begin
    stat.is_free   = (op_r == OPC_FREE);
    stat.fit       = (rd_size_r >= SIZE_W'(units_r));
    stat.exact     = (rd_size_r == SIZE_W'(units_r));
    stat.at_rover  = (p_r == rover_r);
    stat.grow_fail = (CMP_W'(grow_units) > room);
    stat.a_over    = (a_steps_r >= STEP_W'(STEP_LIMIT));
    stat.r_over    = (r_steps_r >= STEP_W'(STEP_LIMIT));
    stat.mod_big   = (q_r >= HEAP_V);
    stat.free_skip = (fa_ext <= ONE_V) || (bp_from_fa >= CMP_W'(brk_r));
    // insertion point: strictly between p and its successor, or at the wrap
    stat.found     = ((bp_r > p_r) && (bp_r < rd_next_r)) ||
                     ((p_r >= rd_next_r) && ((bp_r > p_r) || (bp_r < rd_next_r)));
  end

  // memory port selection
  always_comb begin
    rd_addr = p_r;
    sz_we   = 1'b0;
    sz_wa   = p_r;
    sz_wd   = '0;
    nx_we   = 1'b0;
    nx_wa   = p_r;
    nx_wd   = '0;
    unique case (op)
      OP_SETUP: begin
        if (!started_r) begin
          sz_we = 1'b1;
          sz_wa = '0;
          nx_we = 1'b1;
          nx_wa = '0;
        end
      end
      OP_A_FIRST, OP_A_RET, OP_R_BEGIN: rd_addr = rover_r;
      OP_A_NEXT, OP_A_STEP, OP_A_RET2, OP_R_STEP: rd_addr = rd_next_r;
      OP_A_EXACT: begin
        nx_we = 1'b1;
        nx_wa = prev_r;
        nx_wd = rd_next_r;
      end
      OP_A_SPLIT: begin
        sz_we = 1'b1;
        sz_wd = rem;
      end
      OP_A_TAIL: begin
        sz_we = 1'b1;
        sz_wa = q_r[AW-1:0];
        sz_wd = SIZE_W'(units_r);
      end
      OP_A_GROW: begin
        sz_we = 1'b1;
        sz_wa = brk_r[AW-1:0];
        sz_wd = SIZE_W'(grow_units);
      end
      OP_R_FOUND: rd_addr = bp_r;
      OP_R_RDBP:  rd_addr = n_r;
      OP_R_UPPER: begin
        nx_we = 1'b1;
        nx_wa = bp_r;
        if (upper) begin
          sz_we = 1'b1;
          sz_wa = bp_r;
          sz_wd = up_sum;
          nx_wd = rd_next_r;
        end else begin
          nx_wd = n_r;
        end
      end
      OP_R_LOWER: begin
        nx_we = 1'b1;
        nx_wa = p_r;
        if (lower) begin
          sz_we = 1'b1;
          sz_wa = p_r;
          sz_wd = low_sum;
          nx_wd = next_bp_r;
        end else begin
          nx_wd = bp_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_size_r <= size_mem[rd_addr];
    rd_next_r <= next_mem[rd_addr];
    if (sz_we) begin
      size_mem[sz_wa] <= sz_wd;
    end
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rover_r    <= '0;
      brk_r      <= BW'(1);
      started_r  <= 1'b0;
      min_grow_r <= MIN_GROW_RST;
    end else begin
      if (cfg_wr_en) begin
        min_grow_r <= cfg_wr_data;
      end
      case (op)
        OP_SETUP: begin
          if (!started_r) begin
            rover_r   <= '0;
            started_r <= 1'b1;
          end
        end
        OP_A_EXACT, OP_A_SPLIT: rover_r <= prev_r;
        OP_A_GROW:              brk_r   <= brk_sum[BW-1:0];
        OP_R_LOWER:             rover_r <= p_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        op_r <= in_op;
        x_r  <= X_W'(in_bytes) + X_W'(UNIT_BYTES - 1);
        fa_r <= in_fa;
      end
      OP_SETUP: begin
        // bytes to units through a reciprocal multiply
        prod_r <= PROD_W'(x_r) * PROD_W'(RECIP_V);
        bp_r   <= bp_from_fa[AW-1:0];
      end
      OP_UNITS: units_r <= prod_r[K +: UNITS_W] + UNITS_W'(1);
      OP_A_FIRST: begin
        prev_r    <= rover_r;
        a_steps_r <= '0;
      end
      OP_A_RET: prev_r <= rover_r;
      OP_A_NEXT: p_r <= rd_next_r;
      OP_A_STEP: begin
        prev_r    <= p_r;
        p_r       <= rd_next_r;
        a_steps_r <= a_steps_r + STEP_W'(1);
      end
      OP_A_RET2: begin
        p_r       <= rd_next_r;
        a_steps_r <= a_steps_r + STEP_W'(1);
      end
      OP_A_EXACT: begin
        pend_addr_r <= p_plus1[ADDR_W-1:0];
        pend_st_r   <= ST_ALLOC;
      end
      OP_A_SPLIT: q_r <= split_q;
      OP_A_MOD:   q_r <= q_r - HEAP_V;
      OP_A_TAIL: begin
        pend_addr_r <= q_plus1[ADDR_W-1:0];
        pend_st_r   <= ST_ALLOC;
      end
      OP_A_GROW: bp_r <= brk_r[AW-1:0];
      OP_A_FAIL: begin
        pend_addr_r <= '0;
        pend_st_r   <= ST_OOS;
      end
      OP_R_BEGIN: begin
        p_r       <= rover_r;
        r_steps_r <= '0;
      end
      OP_R_STEP: begin
        p_r       <= rd_next_r;
        r_steps_r <= r_steps_r + STEP_W'(1);
      end
      OP_R_FOUND: begin
        size_p_r <= rd_size_r;
        n_r      <= rd_next_r;
      end
      OP_R_RDBP: size_bp_r <= rd_size_r;
      OP_R_UPPER: begin
        if (upper) begin
          size_bp_r <= up_sum;
          next_bp_r <= rd_next_r;
        end else begin
          next_bp_r <= n_r;
        end
      end
      OP_FREED: begin
        pend_addr_r <= '0;
        pend_st_r   <= ST_FREED;
      end
      OP_OUT: begin
        out_addr_r <= pend_addr_r;
        out_st_r   <= pend_st_r;
      end
      default: ;
    endcase
  end

  assign res_addr   = out_addr_r;
  assign res_status = out_st_r;

endmodule

[sv/free_list_heap_allocator.sv]
// top level of the next-fit free-list heap allocator
//
//  channel | direction | handshake            | payload
//  in_     | request   | in_tvalid/in_tready   | tuser: operation; tdata: bytes, free address
//  out_    | result    | out_tvalid/out_tready | tuser: status; tdata: block address
//  cfg_    | write     | cfg_wr_en             | cfg_wr_data: min_grow_units
//
// allocate: the result follows a walk over the free-list headers from the rover, with a
// further step to place the tail of a split; growing the arena adds a release walk.
// free: a release walk over the headers, none when ignored. one request at a time.
// reset makes no clearing pass over the header memory.
// a waiting result holds back the end of the next request, not its acceptance.
module free_list_heap_allocator
  import fla_pkg::*;
#(
  parameter int HEAP_UNITS = HEAP_UNITS_DEF,
  parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // request_bytes[15:0], free_address[27:16]
  input  logic                   in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // block_address[11:0]
  output logic [STATUS_W-1:0]    out_tuser,  // status
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data // min_grow_units
);

  dp_stat_t          stat;
  dp_op_t            op;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;

  fla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .op         (op)
  );

  fla_dp #(
    .HEAP_UNITS (HEAP_UNITS),
    .UNIT_BYTES (UNIT_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (in_tuser),
    .in_bytes    (in_tdata[BYTES_W-1:0]),
    .in_fa       (in_tdata[BYTES_W +: FA_W]),
    .op          (op),
    .stat        (stat),
    .res_addr    (res_addr),
    .res_status  (res_status)
  );

  assign out_tdata = {{(OUT_TDATA_W - ADDR_W){1'b0}}, res_addr};
  assign out_tuser = res_status;

  // one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_ALLOC) || (out_tuser == ST_OOS) ||
                   (out_tuser == ST_FREED))
    else $error("result carries an undefined status");

  a_no_addr_unless_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_ALLOC) |-> (out_tdata[ADDR_W-1:0] == '0))
    else $error("non-allocation result carries an address");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(in_tready) && $past(!out_tvalid) && in_tready |=> !out_tvalid)
    else $error("result appeared without a request");

endmodule

[test/testbench.sv]
// self-checking testbench for the next-fit free-list heap allocator
module testbench;
  import fla_pkg::*;

  localparam int unsigned WALK_MAX = 4 * HEAP_UNITS_DEF + 16;
  localparam int unsigned SZ_MASK  = 32'h1FFFF;
  localparam int unsigned PAD_W    = IN_TDATA_W - FA_W - BYTES_W;

  typedef struct packed {
    logic                op;
    logic [BYTES_W-1:0]  nbytes;
    logic [FA_W-1:0]     fa;
    logic [ADDR_W-1:0]   want_addr;
    status_t             want_status;
  } heap_req_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  free_list_heap_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow heap: header sizes and links, roving pointer, break
  int unsigned blk_len  [HEAP_UNITS_DEF];
  int unsigned blk_link [HEAP_UNITS_DEF];
  int unsigned roam = 0;
  int unsigned brk_top = 1;
  bit          heap_open = 1'b0;
  int unsigned grow_min = 32'(MIN_GROW_RST);

  heap_req_t   req_backlog[$];
  heap_req_t   results_owed[$];
  heap_req_t   cur_req;
  heap_req_t   due;
  int unsigned live_blocks[$];

  int driven_cnt = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_stall = 0;
  int out_calm = 0;
  int issued_cnt = 0;
  int taken_cnt = 0;
  int err_count = 0;
  int n_placed = 0;
  int n_oos = 0;
  int n_frees = 0;
  int n_cfg = 0;

  function automatic void heap_release(input int unsigned bp);
    int unsigned p;
    int unsigned n;
    int unsigned steps;
    bit found;
    if (bp == 0 || bp >= brk_top) return;
    p = roam;
    steps = 0;
    found = 1'b0;
    while (!found) begin
      n = blk_link[p];
      if ((bp > p && bp < n) || (p >= n && (bp > p || bp < n))) begin
        found = 1'b1;
      end else begin
        p = n;
        steps++;
        // runaway walk on a broken list: the request is dropped
        if (steps > WALK_MAX) return;
      end
    end
    n = blk_link[p];
    if (bp + blk_len[bp] == n) begin
      blk_len[bp] = (blk_len[bp] + blk_len[n]) & SZ_MASK;
      blk_link[bp] = blk_link[n];
    end else begin
      blk_link[bp] = n;
    end
    if (p + blk_len[p] == bp) begin
      blk_len[p] = (blk_len[p] + blk_len[bp]) & SZ_MASK;
      blk_link[p] = blk_link[bp];
    end else begin
      blk_link[p] = bp;
    end
    roam = p;
  endfunction

  function automatic bit heap_grow(input int unsigned units);
    int unsigned g;
    int unsigned up;
    g = (units < grow_min) ? grow_min : units;
    up = brk_top;
    if (g > HEAP_UNITS_DEF - brk_top) return 1'b0;
    blk_len[up] = g & SZ_MASK;
    brk_top += g;
    heap_release(up);
    return 1'b1;
  endfunction

  function automatic void heap_alloc(input int unsigned nbytes, output bit ok,
                                     output int unsigned ua);
    int unsigned units;
    int unsigned prev;
    int unsigned p;
    int unsigned steps;
    bit done;
    units = (nbytes + UNIT_BYTES_DEF - 1) / UNIT_BYTES_DEF + 1;
    prev = roam;
    p = blk_link[roam];
    steps = 0;
    ok = 1'b0;
    ua = 0;
    done = 1'b0;
    while (!done) begin
      if (blk_len[p] >= units) begin
        if (blk_len[p] == units) begin
          blk_link[prev] = blk_link[p];
        end else begin
          // hand out the tail of the larger block
          blk_len[p] -= units;
          p = (p + blk_len[p]) % HEAP_UNITS_DEF;
          blk_len[p] = units & SZ_MASK;
        end
        roam = prev;
        ok = 1'b1;
        ua = p + 1;
        done = 1'b1;
      end else begin
        if (p == roam) begin
          if (!heap_grow(units)) done = 1'b1;
          else p = roam;
        end
        if (!done) begin
          prev = p;
          p = blk_link[p];
          steps++;
          if (steps > WALK_MAX) done = 1'b1;
        end
      end
    end
  endfunction

  function automatic heap_req_t predict_heap_result(input heap_req_t r);
    heap_req_t e;
    bit ok;
    int unsigned ua;
    e = r;
    if (!heap_open) begin
      blk_len[0] = 0;
      blk_link[0] = 0;
      roam = 0;
      heap_open = 1'b1;
    end
    if (r.op == OPC_ALLOC) begin
      heap_alloc(32'(r.nbytes), ok, ua);
      e.want_addr = ok ? ua[ADDR_W-1:0] : '0;
      e.want_status = ok ? ST_ALLOC : ST_OOS;
    end else begin
      if (r.fa != 0) heap_release(32'(r.fa) - 32'd1);
      e.want_addr = '0;
      e.want_status = ST_FREED;
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < 40) $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic post_request(input heap_req_t r, output logic [ADDR_W-1:0] ua);
    heap_req_t e;
    e = predict_heap_result(r);
    req_backlog.push_back(e);
    issued_cnt++;
    ua = e.want_addr;
    case (e.want_status)
      ST_ALLOC: n_placed++;
      ST_OOS:   n_oos++;
      default:  n_frees++;
    endcase
  endtask

  task automatic post_alloc(input logic [BYTES_W-1:0] nbytes, output logic [ADDR_W-1:0] ua);
    heap_req_t r;
    r = '0;
    r.op = OPC_ALLOC;
    r.nbytes = nbytes;
    r.fa = FA_W'($urandom);
    post_request(r, ua);
    // a block at the very top wraps to zero and can never be handed back
    if (ua != 0) live_blocks.push_back(32'(ua));
  endtask

  task automatic post_free(input logic [FA_W-1:0] fa);
    heap_req_t r;
    logic [ADDR_W-1:0] dummy;
    int idx;
    r = '0;
    r.op = OPC_FREE;
    r.nbytes = BYTES_W'($urandom);
    r.fa = fa;
    post_request(r, dummy);
    idx = -1;
    foreach (live_blocks[i]) if (live_blocks[i] == fa && idx < 0) idx = i;
    if (idx >= 0) live_blocks.delete(idx);
  endtask

  task automatic drain_heap;
    while (taken_cnt != issued_cnt || results_owed.size() != 0) @(negedge clk);
  endtask

  task automatic set_grow_min(input logic [CFG_W-1:0] v);
    drain_heap();
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    grow_min = 32'(v);
    n_cfg++;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic run_random(input int count);
    logic [ADDR_W-1:0] ua;
    logic [BYTES_W-1:0] nb;
    int r;
    int b;
    for (int i = 0; i < count; i++) begin
      // hold back once per phase until the allocator has caught up
      if (i == count / 2) drain_heap();
      r = $urandom_range(0, 99);
      if (live_blocks.size() == 0 || (r < 52 && live_blocks.size() < 32)) begin
        b = $urandom_range(0, 99);
        if (b < 65) nb = BYTES_W'($urandom_range(0, 64));
        else if (b < 90) nb = BYTES_W'($urandom_range(65, 512));
        else if (b < 97) nb = BYTES_W'($urandom_range(513, 2048));
        else nb = BYTES_W'($urandom_range(40000, 65535));
        post_alloc(nb, ua);
      end else if (r < 95) begin
        post_free(FA_W'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]));
      end else begin
        b = $urandom_range(0, 2);
        if (b == 2 && brk_top < HEAP_UNITS_DEF - 1)
          post_free(FA_W'($urandom_range(brk_top + 1, HEAP_UNITS_DEF - 1)));
        else
          post_free(b == 1 ? FA_W'(1) : FA_W'(0));
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && taken_cnt != driven_cnt) begin
      // request still waiting for the allocator
    end else begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        cur_req = req_backlog.pop_front();
        driven_cnt++;
        in_tdata <= {{PAD_W{1'b0}}, cur_req.fa, cur_req.nbytes};
        in_tuser <= cur_req.op;
        in_tvalid <= 1'b1;
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
          in_calm = $urandom_range(20, 80);
          in_gap = 0;
        end else if ($urandom_range(0, 1) == 0) begin
          in_gap = 0;
        end else begin
          in_gap = idle_len();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 99) < 2) out_calm = $urandom_range(20, 80);
      else if ($urandom_range(0, 99) < 30) out_stall = idle_len();
    end
  end

  // acceptance tracking and result checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        results_owed.push_back(cur_req);
        taken_cnt++;
      end
      if (out_tvalid && out_tready) begin
        if (results_owed.size() == 0) begin
          report_mismatch($sformatf("unexpected result addr %0d status %0d",
                                    out_tdata[ADDR_W-1:0], out_tuser));
        end else begin
          due = results_owed.pop_front();
          if (out_tdata[ADDR_W-1:0] != due.want_addr)
            report_mismatch($sformatf("op %0d bytes %0d fa %0d: addr %0d, want %0d",
                                      due.op, due.nbytes, due.fa,
                                      out_tdata[ADDR_W-1:0], due.want_addr));
          if (out_tuser != due.want_status)
            report_mismatch($sformatf("op %0d bytes %0d fa %0d: status %0d, want %0d",
                                      due.op, due.nbytes, due.fa,
                                      out_tuser, due.want_status));
        end
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] a, b, c, d, e;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_grow_min(13'd1);
    // the first request opens the list even when it is a free
    post_free(12'd0);
    post_alloc(16'd0, a);
    post_alloc(16'd1, b);
    post_alloc(16'd8, c);
    post_alloc(16'd9, d);
    post_alloc(16'd100, e);
    // middle block between two live ones, then freed twice
    post_free(c);
    post_free(c);
    post_free(b);
    post_free(d);
    post_free(a);
    post_alloc(16'd16, a);
    post_alloc(16'd40, b);
    post_alloc(16'hFFFF, c);
    post_alloc(16'h8000, c);
    post_free(12'd1);
    post_free(12'hFFF);
    post_free(e);
    run_random(180);

    set_grow_min(13'd0);
    run_random(200);
    set_grow_min(CFG_W'($urandom_range(100, 300)));
    run_random(200);
    set_grow_min(13'd4096);
    run_random(200);
    set_grow_min(13'h1FFF);
    run_random(180);
    set_grow_min(CFG_W'($urandom_range(2, 99)));
    run_random(200);

    // fill the arena exactly, then split a header-only block off its top
    while (live_blocks.size() > 0) post_free(FA_W'(live_blocks[0]));
    if (brk_top > 1) post_alloc(BYTES_W'((brk_top - 2) * UNIT_BYTES_DEF), a);
    set_grow_min(13'd1);
    if (brk_top < HEAP_UNITS_DEF) begin
      post_alloc(BYTES_W'((HEAP_UNITS_DEF - brk_top - 1) * UNIT_BYTES_DEF), a);
      post_free(a);
    end
    post_alloc(16'd0, a);
    repeat (4) post_alloc(16'd8, a);
    post_alloc(16'd2000, a);

    drain_heap();
    repeat (50) @(negedge clk);
    $display("ran %0d requests: %0d placed, %0d out of space, %0d frees",
             issued_cnt, n_placed, n_oos, n_frees);
    $display("minimum growth written %0d times, final arena break at unit %0d",
             n_cfg, brk_top);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
